// File: sv/wnt_pkg.sv
// ----------------------------------------------------------------------------
// wnt_pkg
// Shared codes and types of the weighted neighbour table.
// ----------------------------------------------------------------------------
`default_nettype none
package wnt_pkg;

  // command codes
  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_ENHANCE = 3'd1;
  localparam logic [2:0] CMD_DELETE  = 3'd2;
  localparam logic [2:0] CMD_AGE     = 3'd3;
  localparam logic [2:0] CMD_SELECT  = 3'd4;
  localparam logic [2:0] CMD_TOTAL   = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  // configuration register indexes
  localparam logic REG_AGING_FACTOR    = 1'b0;
  localparam logic REG_PRUNE_THRESHOLD = 1'b1;

  localparam int TOTAL_BITS = 38;

  // what every cell of the row does in a cycle
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_SHIFT,
    CM_PACK
  } cell_mode_t;

endpackage
`default_nettype wire

// File: sv/wnt_if.sv
// ----------------------------------------------------------------------------
// wnt_if
// Command, result and configuration channels of the neighbour table.
// ----------------------------------------------------------------------------
`default_nettype none
interface wnt_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [15:0]        neighbor_id;
  logic signed [31:0] amount;
  logic [15:0]        random_fraction;
  modport source (output valid, cmd, neighbor_id, amount, random_fraction, input ready);
  modport sink (input valid, cmd, neighbor_id, amount, random_fraction, output ready);
endinterface

interface wnt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  entry_index;
  logic [15:0] chosen_id;
  logic [31:0] chosen_weight;
  logic [6:0]  entry_count;
  logic [37:0] total_weight;
  modport source (output valid, status, entry_index, chosen_id, chosen_weight,
                  entry_count, total_weight, input ready);
  modport sink (input valid, status, entry_index, chosen_id, chosen_weight,
                entry_count, total_weight, output ready);
endinterface

interface wnt_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/wnt_cell.sv
// ----------------------------------------------------------------------------
// wnt_cell
// One slot of the entry row: holds an ID, a weight and an occupied flag.
// ----------------------------------------------------------------------------
`default_nettype none
module wnt_cell #(
  parameter int ID_BITS = 16
) (
  input  wire                    clk,
  input  wnt_pkg::cell_mode_t    mode,
  input  wire                    lower_full,
  input  wire  [ID_BITS-1:0]     up_id,
  input  wire  [31:0]            up_weight,
  input  wire                    up_full,
  output logic [ID_BITS-1:0]     id,
  output logic [31:0]            weight,
  output logic                   full
);
  import wnt_pkg::*;

  // shift takes the upper neighbour; pack lets entries drop into empty slots
  always_ff @(posedge clk) begin
    case (mode)
      CM_SHIFT: begin
        id     <= up_id;
        weight <= up_weight;
        full   <= up_full;
      end
      CM_PACK: begin
        if (!full) begin
          id     <= up_id;
          weight <= up_weight;
          full   <= up_full;
        end else if (!lower_full) begin
          full <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/weighted_neighbor_table.sv
// ----------------------------------------------------------------------------
// weighted_neighbor_table
// Weighted neighbour table with add, enhance, delete, age, roulette select
// and total weight commands.
// ----------------------------------------------------------------------------
// The entries sit in a row of cells that rotates past a head unit, one entry
// a cycle. Enhance and total take one rotation; add, delete and select take
// a second one only when the add finds room and no duplicate, the delete
// finds its entry or the select sees a nonzero sum; age takes one rotation
// followed by a packing phase. One command is worked on at a time; a new
// one is taken while the previous result still waits on the result channel.
// Configuration writes are taken in every cycle.
`default_nettype none
module weighted_neighbor_table #(
  parameter int MAX_ENTRIES = 64,
  parameter int ID_BITS     = 16
) (
  input  wire       clk,
  input  wire       rst,
  wnt_req_if.sink   req,
  wnt_rsp_if.source rsp,
  wnt_cfg_if.sink   cfg
);
  import wnt_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = $clog2(2 * MAX_ENTRIES);
  localparam int SW = 32 + IW;

  typedef enum logic [2:0] {S_IDLE, S_P1, S_EVAL, S_P2, S_PACK, S_FIN} state_t;

  state_t state;
  logic [CW-1:0] n;
  logic [CW-1:0] kept;
  logic [PW-1:0] p;
  logic [15:0]   factor;
  logic [31:0]   threshold;

  // latched command
  logic [2:0]         c_cmd;
  logic [ID_BITS-1:0] c_id;
  logic signed [31:0] c_amt;
  logic [15:0]        c_frac;

  // search and sum registers
  logic               found;
  logic [IW-1:0]      k;
  logic [31:0]        kw;
  logic [ID_BITS-1:0] last_id;
  logic [31:0]        last_w;
  logic [SW-1:0]      sum;
  logic [SW-1:0]      pre;
  logic [SW-1:0]      r;

  // result registers
  logic [2:0]            res_st;
  logic [IW-1:0]         res_idx;
  logic [ID_BITS-1:0]    res_id;
  logic [31:0]           res_w;
  logic [TOTAL_BITS-1:0] res_tot;

  // the row of cells
  logic [ID_BITS-1:0] cell_id [MAX_ENTRIES];
  logic [31:0]        cell_w  [MAX_ENTRIES];
  logic               cell_f  [MAX_ENTRIES];
  logic [ID_BITS-1:0] tail_id;
  logic [31:0]        tail_w;
  logic               tail_f;
  cell_mode_t         mode;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [ID_BITS-1:0] u_id;
    logic [31:0]        u_w;
    logic               u_f;
    logic               lo_f;
    if (i == MAX_ENTRIES - 1) begin : g_top
      assign u_id = tail_id;
      assign u_w  = tail_w;
      assign u_f  = tail_f;
    end else begin : g_mid
      assign u_id = cell_id[i+1];
      assign u_w  = cell_w[i+1];
      assign u_f  = cell_f[i+1];
    end
    if (i == 0) begin : g_bot
      assign lo_f = 1'b1;
    end else begin : g_up
      assign lo_f = cell_f[i-1];
    end
    wnt_cell #(.ID_BITS(ID_BITS)) u_cell (
      .clk        (clk),
      .mode       (mode),
      .lower_full (lo_f),
      .up_id      (u_id),
      .up_weight  (u_w),
      .up_full    (u_f),
      .id         (cell_id[i]),
      .weight     (cell_w[i]),
      .full       (cell_f[i])
    );
  end

  // head unit: the entry at the bottom cell has index p
  logic [ID_BITS-1:0] h_id;
  logic [31:0]        h_w;
  logic               in_range;
  logic               id_match;
  logic               p_last;
  logic signed [33:0] enh_sum;
  logic [31:0]        enh_w;
  logic [47:0]        aged_full;
  logic [31:0]        aged;
  logic               keep;
  logic [SW-1:0]      add_sel;
  logic [SW-1:0]      add_all;
  logic [SW-1:0]      pre_nx;
  logic [31:0]        add_w;
  logic [SW+15:0]     scaled;
  logic [TOTAL_BITS-1:0] tot_sat;

  always_comb begin
    h_id      = cell_id[0];
    h_w       = cell_w[0];
    in_range  = p < PW'(n);
    id_match  = h_id == c_id;
    p_last    = p == PW'(MAX_ENTRIES - 1);
    enh_sum   = $signed({2'b00, h_w}) + 34'(c_amt);
    if (enh_sum < 0) enh_w = 32'd0;
    else if (enh_sum[32]) enh_w = 32'hFFFF_FFFF;
    else enh_w = enh_sum[31:0];
    aged_full = h_w * factor;
    aged      = aged_full[47:16];
    keep      = in_range && (aged >= threshold);
    add_sel   = (in_range && !id_match) ? SW'(h_w) : '0;
    add_all   = in_range ? SW'(h_w) : '0;
    pre_nx    = pre + add_sel;
    add_w     = c_amt[31] ? 32'd0 : c_amt;
    scaled    = sum * c_frac;
    tot_sat   = ((SW > TOTAL_BITS) && ((sum >> TOTAL_BITS) != '0)) ? '1 : TOTAL_BITS'(sum);
  end

  // what enters the top cell, and the row's mode
  always_comb begin
    tail_id = h_id;
    tail_w  = h_w;
    tail_f  = cell_f[0];
    mode    = CM_HOLD;
    case (state)
      S_P1: begin
        mode = CM_SHIFT;
        if (c_cmd == CMD_ENHANCE && in_range && id_match && !found) tail_w = enh_w;
        if (c_cmd == CMD_AGE) begin
          tail_w = aged;
          tail_f = keep;
        end
      end
      S_P2: begin
        mode = CM_SHIFT;
        if (c_cmd == CMD_ADD && p == PW'(n)) begin
          tail_id = c_id;
          tail_w  = add_w;
        end
        if (c_cmd == CMD_DELETE && p == PW'(k)) begin
          tail_id = last_id;
          tail_w  = last_w;
        end
      end
      S_PACK: begin
        mode   = CM_PACK;
        tail_f = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign req.ready = state == S_IDLE;
  assign cfg.ready = 1'b1;

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      factor    <= 16'hFFFF;
      threshold <= 32'd0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == REG_AGING_FACTOR) factor <= cfg.data[15:0];
        else threshold <= cfg.data;
      end
      if (rsp.valid && rsp.ready && state != S_FIN) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            c_cmd   <= req.cmd;
            c_id    <= ID_BITS'(req.neighbor_id);
            c_amt   <= req.amount;
            c_frac  <= req.random_fraction;
            p       <= '0;
            found   <= 1'b0;
            sum     <= '0;
            pre     <= '0;
            kept    <= '0;
            res_st  <= ST_OK;
            res_idx <= '0;
            res_id  <= '0;
            res_w   <= '0;
            res_tot <= '0;
            state   <= S_P1;
          end
        end
        S_P1: begin
          p <= p_last ? '0 : p + 1'b1;
          if (p_last) state <= S_EVAL;
          case (c_cmd)
            CMD_ADD, CMD_DELETE, CMD_ENHANCE: begin
              if (in_range && id_match && !found) begin
                found <= 1'b1;
                k     <= IW'(p);
                kw    <= (c_cmd == CMD_ENHANCE) ? enh_w : h_w;
              end
              if (p == PW'(n) - 1'b1) begin
                last_id <= h_id;
                last_w  <= h_w;
              end
            end
            CMD_AGE: begin
              if (keep) kept <= kept + 1'b1;
            end
            CMD_SELECT: begin
              sum <= sum + add_sel;
              if (p == PW'(n) - 1'b1) begin
                res_idx <= IW'(p);
                res_id  <= h_id;
                res_w   <= h_w;
              end
            end
            CMD_TOTAL: sum <= sum + add_all;
            default: begin
            end
          endcase
        end
        S_EVAL: begin
          state <= S_FIN;
          case (c_cmd)
            CMD_ADD: begin
              if (found) begin
                res_st  <= ST_DUP;
                res_idx <= k;
                res_id  <= c_id;
                res_w   <= kw;
              end else if (n == CW'(MAX_ENTRIES)) begin
                res_st <= ST_FULL;
              end else begin
                state <= S_P2;
              end
            end
            CMD_ENHANCE: begin
              if (found) begin
                res_idx <= k;
                res_id  <= c_id;
                res_w   <= kw;
              end else begin
                res_st <= ST_NOTFOUND;
              end
            end
            CMD_DELETE: begin
              if (found) state <= S_P2;
              else res_st <= ST_NOTFOUND;
            end
            CMD_AGE: begin
              n     <= kept;
              state <= S_PACK;
            end
            CMD_SELECT: begin
              if (sum == '0) begin
                res_st  <= ST_NONE;
                res_idx <= '0;
                res_id  <= '0;
                res_w   <= '0;
              end else begin
                r     <= scaled[SW+15:16];
                state <= S_P2;
              end
            end
            CMD_TOTAL: res_tot <= tot_sat;
            default: begin
            end
          endcase
        end
        S_P2: begin
          p <= p_last ? '0 : p + 1'b1;
          case (c_cmd)
            CMD_SELECT: begin
              pre <= pre_nx;
              if (in_range && !found && pre_nx > r) begin
                found   <= 1'b1;
                res_idx <= IW'(p);
                res_id  <= h_id;
                res_w   <= h_w;
              end
            end
            default: begin
            end
          endcase
          if (p_last) begin
            state <= S_FIN;
            if (c_cmd == CMD_ADD) begin
              n       <= n + 1'b1;
              res_idx <= IW'(n);
              res_id  <= c_id;
              res_w   <= add_w;
            end
            if (c_cmd == CMD_DELETE) begin
              n       <= n - 1'b1;
              res_idx <= k;
              res_id  <= c_id;
              res_w   <= kw;
            end
          end
        end
        S_PACK: begin
          p <= p + 1'b1;
          if (p == PW'(2 * MAX_ENTRIES - 1)) state <= S_FIN;
        end
        S_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid         <= 1'b1;
            rsp.status        <= res_st;
            rsp.entry_index   <= 6'(res_idx);
            rsp.chosen_id     <= 16'(res_id);
            rsp.chosen_weight <= res_w;
            rsp.entry_count   <= 7'(n);
            rsp.total_weight  <= res_tot;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    n <= CW'(MAX_ENTRIES)) else $error("entry count beyond table size");

  a_add_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_P2 && c_cmd == CMD_ADD) |-> n < CW'(MAX_ENTRIES))
    else $error("add placed into a full table");

  a_fin_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!rsp.valid || rsp.ready)) |=> rsp.valid && state == S_IDLE)
    else $error("result beat not issued on completion");

endmodule
`default_nettype wire

// File: tb/sv/tb_weighted_neighbor_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weighted_neighbor_table
// Self-checking bench for the weighted neighbour table. Command beats are
// taken from a queue by a clocked driver. A mirror of the table, kept in the
// bench, works out the awaited result of every accepted beat. A monitor
// compares each result beat field by field. The run sweeps the aging and
// prune settings and several idle and stall patterns, and holds the result
// channel off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_weighted_neighbor_table;
  import wnt_pkg::*;

  localparam int SLOTS = 64;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int SETTLE = 250;

  typedef struct {
    logic [2:0]         cmd;
    logic [15:0]        id;
    logic signed [31:0] amount;
    logic [15:0]        frac;
  } cmd_beat_t;

  typedef struct {
    logic [2:0]  status;
    logic [5:0]  idx;
    logic [15:0] id;
    logic [31:0] weight;
    logic [6:0]  count;
    logic [37:0] total;
  } table_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wnt_req_if req_ch ();
  wnt_rsp_if rsp_ch ();
  wnt_cfg_if cfg_ch ();

  weighted_neighbor_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // mirror of the table
  logic [15:0] mirror_ids [SLOTS];
  logic [31:0] mirror_wts [SLOTS];
  int          mirror_count;
  logic [15:0] mirror_aging;
  logic [31:0] mirror_thresh;

  cmd_beat_t     pending_cmds [$];
  table_answer_t awaited_answers [$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  logic hold_off = 1'b0;
  int errors = 0;
  int accepted = 0;
  int answered = 0;
  int status_seen [5];

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t on %s: got %0h, want %0h", $realtime, field, got, want);
    errors++;
  endtask

  // work out the result of one command and update the mirror
  task automatic run_table_command(input cmd_beat_t b);
    table_answer_t a;
    int hit;
    int kept;
    longint sw;
    logic [63:0] sum;
    logic [63:0] pick;
    logic [63:0] w64;
    logic [63:0] prefix [SLOTS];
    a = '{default: '0};
    hit = -1;
    for (int i = 0; i < mirror_count; i++)
      if (hit < 0 && mirror_ids[i] == b.id) hit = i;
    case (b.cmd)
      CMD_ADD: begin
        if (hit >= 0) begin
          a.status = ST_DUP;
          a.idx = hit[5:0];
          a.id = b.id;
          a.weight = mirror_wts[hit];
        end else if (mirror_count >= SLOTS) begin
          a.status = ST_FULL;
        end else begin
          mirror_ids[mirror_count] = b.id;
          mirror_wts[mirror_count] = b.amount < 0 ? 32'd0 : b.amount;
          a.idx = mirror_count[5:0];
          a.id = b.id;
          a.weight = mirror_wts[mirror_count];
          mirror_count++;
        end
      end
      CMD_ENHANCE: begin
        if (hit < 0) begin
          a.status = ST_NOTFOUND;
        end else begin
          sw = longint'(mirror_wts[hit]) + longint'(b.amount);
          if (sw < 0) sw = 0;
          if (sw > 64'sh0_FFFF_FFFF) sw = 64'sh0_FFFF_FFFF;
          mirror_wts[hit] = sw[31:0];
          a.idx = hit[5:0];
          a.id = b.id;
          a.weight = sw[31:0];
        end
      end
      CMD_DELETE: begin
        if (hit < 0) begin
          a.status = ST_NOTFOUND;
        end else begin
          a.idx = hit[5:0];
          a.id = b.id;
          a.weight = mirror_wts[hit];
          mirror_ids[hit] = mirror_ids[mirror_count-1];
          mirror_wts[hit] = mirror_wts[mirror_count-1];
          mirror_count--;
        end
      end
      CMD_AGE: begin
        kept = 0;
        for (int i = 0; i < mirror_count; i++) begin
          w64 = (64'(mirror_wts[i]) * 64'(mirror_aging)) >> 16;
          if (w64[31:0] >= mirror_thresh) begin
            mirror_ids[kept] = mirror_ids[i];
            mirror_wts[kept] = w64[31:0];
            kept++;
          end
        end
        mirror_count = kept;
      end
      CMD_SELECT: begin
        sum = '0;
        for (int i = 0; i < mirror_count; i++) begin
          if (mirror_ids[i] != b.id) sum += 64'(mirror_wts[i]);
          prefix[i] = sum;
        end
        if (sum == 0) begin
          a.status = ST_NONE;
        end else begin
          pick = (sum >> 16) * 64'(b.frac) + (((sum & 64'hFFFF) * 64'(b.frac)) >> 16);
          hit = mirror_count - 1;
          for (int i = mirror_count - 1; i >= 0; i--)
            if (prefix[i] > pick) hit = i;
          a.idx = hit[5:0];
          a.id = mirror_ids[hit];
          a.weight = mirror_wts[hit];
        end
      end
      CMD_TOTAL: begin
        sum = '0;
        for (int i = 0; i < mirror_count; i++) sum += 64'(mirror_wts[i]);
        if (sum > 64'h3F_FFFF_FFFF) sum = 64'h3F_FFFF_FFFF;
        a.total = sum[37:0];
      end
      default: ;
    endcase
    a.count = mirror_count[6:0];
    awaited_answers.insert(awaited_answers.size(), a);
  endtask

  // driver: one command beat offered at a time, predicted on acceptance
  always @(posedge clk) begin
    cmd_beat_t b;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) begin
        run_table_command('{req_ch.cmd, req_ch.neighbor_id, req_ch.amount,
                            req_ch.random_fraction});
        accepted++;
      end
      if (pending_cmds.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        b = pending_cmds.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.cmd <= b.cmd;
        req_ch.neighbor_id <= b.id;
        req_ch.amount <= b.amount;
        req_ch.random_fraction <= b.frac;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result channel back-pressure
  always @(posedge clk) begin
    rsp_ch.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
  end

  // monitor: each result beat against the oldest awaited answer
  always @(posedge clk) begin
    table_answer_t a;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      answered++;
      if (awaited_answers.size() == 0) begin
        report_mismatch("unexpected result beat", 64'(rsp_ch.status), 0);
      end else begin
        a = awaited_answers.pop_front();
        if (a.status < 5) status_seen[a.status]++;
        if (rsp_ch.status !== a.status) report_mismatch("status", 64'(rsp_ch.status), 64'(a.status));
        if (rsp_ch.entry_index !== a.idx)
          report_mismatch("entry_index", 64'(rsp_ch.entry_index), 64'(a.idx));
        if (rsp_ch.chosen_id !== a.id) report_mismatch("chosen_id", 64'(rsp_ch.chosen_id), 64'(a.id));
        if (rsp_ch.chosen_weight !== a.weight)
          report_mismatch("chosen_weight", 64'(rsp_ch.chosen_weight), 64'(a.weight));
        if (rsp_ch.entry_count !== a.count)
          report_mismatch("entry_count", 64'(rsp_ch.entry_count), 64'(a.count));
        if (rsp_ch.total_weight !== a.total)
          report_mismatch("total_weight", 64'(rsp_ch.total_weight), 64'(a.total));
      end
    end
  end

  function automatic cmd_beat_t beat(input logic [2:0] cmd, input logic [15:0] id,
                                     input logic [31:0] amount, input logic [15:0] frac);
    cmd_beat_t b;
    b.cmd = cmd;
    b.id = id;
    b.amount = amount;
    b.frac = frac;
    return b;
  endfunction

  // append one command beat to the pending queue
  task automatic add_cmd(input cmd_beat_t b);
    pending_cmds.insert(pending_cmds.size(), b);
  endtask

  function automatic logic [15:0] pick_id();
    return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(79));
  endfunction

  function automatic logic [31:0] pick_amount();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h0004_0000);
      2: return -$urandom_range(1, 32'h0002_0000);
      default: return $urandom & 32'h00FF_FFFF;
    endcase
  endfunction

  // mostly table traffic on a small id pool, so hits, misses and dups occur
  task automatic queue_random(input int n);
    int p;
    logic [2:0] c;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      c = p < 35 ? CMD_ADD : p < 55 ? CMD_ENHANCE : p < 67 ? CMD_DELETE :
          p < 71 ? CMD_AGE : p < 92 ? CMD_SELECT : CMD_TOTAL;
      add_cmd(beat(c, pick_id(), pick_amount(), 16'($urandom)));
    end
  endtask

  // fill the table past its size, then probe a duplicate and a select
  task automatic queue_fill();
    for (int i = 0; i < SLOTS + 2; i++)
      add_cmd(beat(CMD_ADD, 16'(1000 + i), pick_amount(), 16'd0));
    add_cmd(beat(CMD_ADD, 16'd1000, 32'd5, 16'd0));
    add_cmd(beat(CMD_SELECT, 16'd1001, 32'd0, 16'hFFFF));
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || req_ch.valid || awaited_answers.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [31:0] data);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (index == REG_AGING_FACTOR) mirror_aging = data[15:0];
    else mirror_thresh = data;
  endtask

  task automatic set_idling(input int src, input int snk);
    wait_drained();
    src_idle_pct = src;
    snk_stall_pct = snk;
  endtask

  // long hold-off on the result channel, counted here
  initial begin
    wait (accepted >= 250);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (1200) @(posedge clk);
    hold_off <= 1'b0;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("tb_weighted_neighbor_table failed");
    $finish;
  end

  // stimulus and phases
  initial begin
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_AGING_FACTOR;
    cfg_ch.data <= '0;
    mirror_count = 0;
    mirror_aging = 16'hFFFF;
    mirror_thresh = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, clamps, misses, exclusion and unused codes
    add_cmd(beat(CMD_SELECT, 16'd0, 32'd0, 16'h8000));
    add_cmd(beat(CMD_TOTAL, 16'd0, 32'd0, 16'd0));
    add_cmd(beat(CMD_ADD, 16'd0, 32'h7FFF_FFFF, 16'd0));
    add_cmd(beat(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFB, 16'd0));
    add_cmd(beat(CMD_ADD, 16'd0, 32'd1, 16'd0));
    add_cmd(beat(CMD_SELECT, 16'd0, 32'd0, 16'hFFFF));
    add_cmd(beat(CMD_ENHANCE, 16'd0, 32'h7FFF_FFFF, 16'd0));
    add_cmd(beat(CMD_ENHANCE, 16'd0, 32'h7FFF_FFFF, 16'd0));
    add_cmd(beat(CMD_ENHANCE, 16'hFFFF, 32'h8000_0000, 16'd0));
    add_cmd(beat(CMD_ENHANCE, 16'd5, 32'd9, 16'd0));
    add_cmd(beat(CMD_DELETE, 16'd5, 32'd0, 16'd0));
    add_cmd(beat(CMD_ADD, 16'd3, 32'h0001_0000, 16'd0));
    add_cmd(beat(CMD_SELECT, 16'hFFFF, 32'd0, 16'd0));
    add_cmd(beat(CMD_SELECT, 16'hFFFF, 32'd0, 16'hFFFF));
    add_cmd(beat(CMD_TOTAL, 16'd0, 32'd0, 16'd0));
    add_cmd(beat(CMD_SPARE6, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
    add_cmd(beat(CMD_SPARE7, 16'd0, 32'd0, 16'd0));
    add_cmd(beat(CMD_DELETE, 16'd0, 32'd0, 16'd0));
    add_cmd(beat(CMD_AGE, 16'd0, 32'd0, 16'd0));
    add_cmd(beat(CMD_SELECT, 16'd7, 32'd0, 16'h1234));
    add_cmd(beat(CMD_DELETE, 16'd3, 32'd0, 16'd0));
    add_cmd(beat(CMD_DELETE, 16'hFFFF, 32'd0, 16'd0));
    add_cmd(beat(CMD_TOTAL, 16'd0, 32'd0, 16'd0));

    // no idling, default settings, table filled to the brim
    queue_fill();
    queue_random(60);

    // halving with a modest prune level, sender idling
    write_reg(REG_AGING_FACTOR, 32'h0000_8000);
    write_reg(REG_PRUNE_THRESHOLD, 32'h0000_4000);
    set_idling(62, 0);
    queue_random(70);

    // receiver stalling; the long hold-off falls in here
    set_idling(0, 62);
    queue_fill();
    queue_random(60);

    // extremes: zero factor and threshold, then top factor and top threshold
    write_reg(REG_AGING_FACTOR, 32'h0000_0000);
    write_reg(REG_PRUNE_THRESHOLD, 32'h0000_0000);
    set_idling(8, 8);
    queue_random(40);
    write_reg(REG_AGING_FACTOR, 32'hFFFF_FFFF);
    write_reg(REG_PRUNE_THRESHOLD, 32'hFFFF_FFFF);
    queue_random(40);

    // random settings, no idling
    write_reg(REG_AGING_FACTOR, $urandom);
    write_reg(REG_PRUNE_THRESHOLD, $urandom & 32'h0003_FFFF);
    set_idling(0, 0);
    queue_random(40);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (awaited_answers.size() != 0) report_mismatch("answers left over", 0, 0);
    $display("commands accepted %0d, results checked %0d", accepted, answered);
    $display("ok %0d, not found %0d, full %0d, duplicate %0d, no eligible %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (errors == 0)
      $display("tb_weighted_neighbor_table passed");
    else
      $display("tb_weighted_neighbor_table failed");
    $finish;
  end

endmodule

// File: weighted_neighbor_table.f
sv/wnt_pkg.sv
sv/wnt_if.sv
sv/wnt_cell.sv
sv/weighted_neighbor_table.sv
tb/sv/tb_weighted_neighbor_table.sv
